[hdl/sha1_pkg.sv]
// Shared types and constants for the SHA-1 hash engine.
// Used by the controller, the datapath and the top level; no dependencies.
package sha1_pkg;

    // Round counter width and round boundaries
    localparam int unsigned ROUND_W = 7;
    localparam logic [ROUND_W-1:0] ROUND_LAST   = 7'd79;
    localparam logic [ROUND_W-1:0] ROUND_PH1    = 7'd20;
    localparam logic [ROUND_W-1:0] ROUND_PH2    = 7'd40;
    localparam logic [ROUND_W-1:0] ROUND_PH3    = 7'd60;

    // Digest word index
    localparam int unsigned IDX_W = 3;
    localparam logic [IDX_W-1:0] IDX_FIRST = 3'd0;
    localparam logic [IDX_W-1:0] IDX_LAST  = 3'd4;

    // Round constants
    localparam logic [31:0] K_CH   = 32'h5A827999;
    localparam logic [31:0] K_PAR1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_MAJ  = 32'h8F1BBCDC;
    localparam logic [31:0] K_PAR2 = 32'hCA62C1D6;

    // Initial chaining values, h0 first
    localparam logic [0:4][31:0] H_INIT = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // Padding marker byte
    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMP,
        ST_ADD,
        ST_PAD,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        PAD_MARK,
        PAD_ZERO,
        PAD_LEN
    } pad_sel_t;

    typedef enum logic [1:0] {
        PH_CH,
        PH_PAR1,
        PH_MAJ,
        PH_PAR2
    } phase_t;

    // Controller to datapath
    typedef struct packed {
        logic             take_byte;
        logic             pad_shift;
        logic             pad_first;
        pad_sel_t         pad_sel;
        logic             load_work;
        logic             round_en;
        phase_t           phase;
        logic             chain_add;
        logic             chain_init;
        logic [IDX_W-1:0] out_idx;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic fill_last;   // next message byte completes a block
        logic pad_last;    // current pad byte completes a block
        logic pad_in_len;  // current pad position is in the length field
    } status_t;

endpackage

[hdl/sha1_if.sv]
// Handshake channels of the SHA-1 engine: message words in, digest words out.
// Depends on nothing.
interface sha1_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       byte_valid;
    logic       end_of_message;

    modport source (output valid, msg_byte, byte_valid, end_of_message, input ready);
    modport sink   (input valid, msg_byte, byte_valid, end_of_message, output ready);
endinterface

interface sha1_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

[hdl/sha1_hash_engine.sv]
// SHA-1 hash engine, top level: joins the controller and the datapath (sha1_pkg, sha1_if).
// Message bytes are taken only while idle; a full 64-byte block then runs 80 rounds in
// one round unit and a chaining add, with intake closed until both are done.
// End of message: pad from the fill position p (an extra block when p is 56..63);
// padded blocks run the same way, then five digest words, one per cycle while ready.
// Reset: chaining words to the SHA-1 initial values, length to zero, idle.
module sha1_hash_engine (
    input  logic              clk,
    input  logic              rst_n,
    sha1_in_if.sink           msg,
    sha1_out_if.source        digest
);

    sha1_pkg::cmd_t     cmd;
    sha1_pkg::status_t  status;

    sha1_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (msg.valid),
        .in_byte_valid (msg.byte_valid),
        .in_eom        (msg.end_of_message),
        .in_ready      (msg.ready),
        .out_valid     (digest.valid),
        .out_ready     (digest.ready),
        .status        (status),
        .cmd           (cmd)
    );

    sha1_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .msg_byte    (msg.msg_byte),
        .status      (status),
        .digest_word (digest.digest_word)
    );

    assign digest.word_index = cmd.out_idx;
    assign digest.last_word  = (cmd.out_idx == sha1_pkg::IDX_LAST);

endmodule

[hdl/sha1_ctrl.sv]
// Control state machine of the SHA-1 engine: intake, rounds, padding, output.
// Depends on sha1_pkg.
module sha1_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_byte_valid,
    input  logic                      in_eom,
    output logic                      in_ready,
    output logic                      out_valid,
    input  logic                      out_ready,
    input  sha1_pkg::status_t         status,
    output sha1_pkg::cmd_t            cmd
);

    sha1_pkg::state_t                  state_reg, state_next;
    logic [sha1_pkg::ROUND_W-1:0]      round_reg, round_next;
    logic [sha1_pkg::IDX_W-1:0]        idx_reg, idx_next;
    logic                              eom_pend_reg, eom_pend_next;
    logic                              from_pad_reg, from_pad_next;
    logic                              len_blk_reg, len_blk_next;
    logic                              pad_first_reg, pad_first_next;

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sha1_pkg::ST_IDLE;
            round_reg     <= '0;
            idx_reg       <= sha1_pkg::IDX_FIRST;
            eom_pend_reg  <= 1'b0;
            from_pad_reg  <= 1'b0;
            len_blk_reg   <= 1'b0;
            pad_first_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            idx_reg       <= idx_next;
            eom_pend_reg  <= eom_pend_next;
            from_pad_reg  <= from_pad_next;
            len_blk_reg   <= len_blk_next;
            pad_first_reg <= pad_first_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next     = state_reg;
        round_next     = round_reg;
        idx_next       = idx_reg;
        eom_pend_next  = eom_pend_reg;
        from_pad_next  = from_pad_reg;
        len_blk_next   = len_blk_reg;
        pad_first_next = pad_first_reg;
        case (state_reg)
            sha1_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_byte_valid && status.fill_last)
                    begin
                        state_next    = sha1_pkg::ST_COMP;
                        round_next    = '0;
                        eom_pend_next = in_eom;
                        from_pad_next = 1'b0;
                    end
                    else if (in_eom)
                    begin
                        state_next     = sha1_pkg::ST_PAD;
                        pad_first_next = 1'b1;
                    end
                end
            end
            sha1_pkg::ST_COMP:
            begin
                round_next = round_reg + 1'b1;
                if (round_reg == sha1_pkg::ROUND_LAST)
                    state_next = sha1_pkg::ST_ADD;
            end
            sha1_pkg::ST_ADD:
            begin
                if (from_pad_reg)
                begin
                    if (len_blk_reg)
                    begin
                        state_next = sha1_pkg::ST_OUT;
                        idx_next   = sha1_pkg::IDX_FIRST;
                    end
                    else
                    begin
                        // marker landed in the length field: one more block
                        state_next     = sha1_pkg::ST_PAD;
                        pad_first_next = 1'b0;
                        len_blk_next   = 1'b1;
                    end
                end
                else if (eom_pend_reg)
                begin
                    state_next     = sha1_pkg::ST_PAD;
                    pad_first_next = 1'b1;
                end
                else
                    state_next = sha1_pkg::ST_IDLE;
            end
            sha1_pkg::ST_PAD:
            begin
                pad_first_next = 1'b0;
                if (pad_first_reg)
                    len_blk_next = !status.pad_in_len;
                if (status.pad_last)
                begin
                    state_next    = sha1_pkg::ST_COMP;
                    round_next    = '0;
                    from_pad_next = 1'b1;
                end
            end
            sha1_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    if (idx_reg == sha1_pkg::IDX_LAST)
                        state_next = sha1_pkg::ST_IDLE;
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end
            default:
                state_next = sha1_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath commands
    always_comb
    begin
        in_ready       = (state_reg == sha1_pkg::ST_IDLE);
        out_valid      = (state_reg == sha1_pkg::ST_OUT);
        cmd.take_byte  = in_ready && in_valid && in_byte_valid;
        cmd.pad_shift  = (state_reg == sha1_pkg::ST_PAD);
        cmd.pad_first  = pad_first_reg;
        cmd.load_work  = (cmd.take_byte && status.fill_last)
                      || (cmd.pad_shift && status.pad_last);
        cmd.round_en   = (state_reg == sha1_pkg::ST_COMP);
        cmd.chain_add  = (state_reg == sha1_pkg::ST_ADD);
        cmd.chain_init = out_valid && out_ready && (idx_reg == sha1_pkg::IDX_LAST);
        cmd.out_idx    = idx_reg;

        if (pad_first_reg)
            cmd.pad_sel = sha1_pkg::PAD_MARK;
        else if (len_blk_reg && status.pad_in_len)
            cmd.pad_sel = sha1_pkg::PAD_LEN;
        else
            cmd.pad_sel = sha1_pkg::PAD_ZERO;

        if (round_reg < sha1_pkg::ROUND_PH1)
            cmd.phase = sha1_pkg::PH_CH;
        else if (round_reg < sha1_pkg::ROUND_PH2)
            cmd.phase = sha1_pkg::PH_PAR1;
        else if (round_reg < sha1_pkg::ROUND_PH3)
            cmd.phase = sha1_pkg::PH_MAJ;
        else
            cmd.phase = sha1_pkg::PH_PAR2;
    end

    // Intake and output never open at once
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while digest is shown");

    // Round counter stays within the 80 rounds
    a_round: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha1_pkg::ST_COMP) |-> (round_reg <= sha1_pkg::ROUND_LAST))
        else $error("round counter out of range");

    // Last round is followed by the chaining add
    a_add: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha1_pkg::ST_COMP && round_reg == sha1_pkg::ROUND_LAST)
        |=> (state_reg == sha1_pkg::ST_ADD))
        else $error("chaining add skipped");

    // Taking the fifth digest word returns to intake
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.chain_init |=> (state_reg == sha1_pkg::ST_IDLE && idx_reg == sha1_pkg::IDX_LAST))
        else $error("engine did not return to idle after digest");

endmodule

[hdl/sha1_dp.sv]
// Datapath of the SHA-1 engine: block/schedule window, round unit, chaining words.
// Depends on sha1_pkg.
module sha1_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sha1_pkg::cmd_t                cmd,
    input  logic [7:0]                    msg_byte,
    output sha1_pkg::status_t             status,
    output logic [31:0]                   digest_word
);

    // 16-word window: block bytes during intake, message schedule during rounds
    logic [511:0]        blk_reg, blk_next;
    logic [63:0]         bit_count_reg, bit_count_next;
    logic [5:0]          pad_pos_reg, pad_pos_next;
    logic [0:4][31:0]    chain_reg, chain_next;
    logic [31:0]         a_reg, b_reg, c_reg, d_reg, e_reg;

    logic [5:0]          pad_q;
    logic [63:0]         len_shift;
    logic [7:0]          pad_byte;
    logic [7:0]          shift_byte;
    logic [31:0]         w_cur, w_mix, w_new;
    logic [31:0]         f_val, k_val, t_val;

    // Pad position: the first pad byte lands at the fill position
    assign pad_q      = cmd.pad_first ? bit_count_reg[8:3] : pad_pos_reg;
    assign len_shift  = bit_count_reg >> {~pad_q[2:0], 3'b000};

    always_comb
    begin
        case (cmd.pad_sel)
            sha1_pkg::PAD_MARK: pad_byte = sha1_pkg::PAD_MARK_BYTE;
            sha1_pkg::PAD_LEN:  pad_byte = len_shift[7:0];
            default:            pad_byte = 8'h00;
        endcase
    end

    assign shift_byte = cmd.take_byte ? msg_byte : pad_byte;

    assign status.fill_last  = (bit_count_reg[8:3] == 6'd63);
    assign status.pad_last   = (pad_q == 6'd63);
    assign status.pad_in_len = (pad_q[5:3] == 3'b111);

    // Schedule: w[t+16] = rotl1(w[t+13] ^ w[t+8] ^ w[t+2] ^ w[t])
    assign w_cur = blk_reg[511:480];
    assign w_mix = blk_reg[95:64] ^ blk_reg[255:224] ^ blk_reg[447:416] ^ w_cur;
    assign w_new = {w_mix[30:0], w_mix[31]};

    // Round function and constant
    always_comb
    begin
        case (cmd.phase)
            sha1_pkg::PH_CH:
            begin
                f_val = (b_reg & c_reg) | (~b_reg & d_reg);
                k_val = sha1_pkg::K_CH;
            end
            sha1_pkg::PH_PAR1:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = sha1_pkg::K_PAR1;
            end
            sha1_pkg::PH_MAJ:
            begin
                f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
                k_val = sha1_pkg::K_MAJ;
            end
            default:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = sha1_pkg::K_PAR2;
            end
        endcase
    end

    assign t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_cur;

    // Window and counters
    always_comb
    begin
        blk_next       = blk_reg;
        bit_count_next = bit_count_reg;
        pad_pos_next   = pad_pos_reg;
        if (cmd.take_byte || cmd.pad_shift)
            blk_next = {blk_reg[503:0], shift_byte};
        else if (cmd.round_en)
            blk_next = {blk_reg[479:0], w_new};
        if (cmd.take_byte)
            bit_count_next = bit_count_reg + 64'd8;
        else if (cmd.chain_init)
            bit_count_next = '0;
        if (cmd.pad_shift)
            pad_pos_next = pad_q + 6'd1;
    end

    // Chaining words
    always_comb
    begin
        chain_next = chain_reg;
        if (cmd.chain_init)
            chain_next = sha1_pkg::H_INIT;
        else if (cmd.chain_add)
        begin
            chain_next[0] = chain_reg[0] + a_reg;
            chain_next[1] = chain_reg[1] + b_reg;
            chain_next[2] = chain_reg[2] + c_reg;
            chain_next[3] = chain_reg[3] + d_reg;
            chain_next[4] = chain_reg[4] + e_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_count_reg <= '0;
            chain_reg     <= sha1_pkg::H_INIT;
        end
        else
        begin
            bit_count_reg <= bit_count_next;
            chain_reg     <= chain_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        blk_reg     <= blk_next;
        pad_pos_reg <= pad_pos_next;
        if (cmd.load_work)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end
        else if (cmd.round_en)
        begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    assign digest_word = chain_reg[cmd.out_idx];

    // Bit counter only moves in whole bytes
    a_bits: assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg[2:0] == 3'b000)
        else $error("bit counter lost byte alignment");

    // Message length is frozen while padding reads it
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pad_shift && !cmd.pad_first) |-> $stable(bit_count_reg))
        else $error("length changed during padding");

endmodule

[test/sha1_hash_engine_test.sv]
// Testbench for sha1_hash_engine: streams messages byte by byte, checks every digest word.
// Expected digests come from a SHA-1 model in the scoreboard class below.
// Depends on sha1_pkg (via the RTL), sha1_in_if, sha1_out_if and sha1_hash_engine.
module sha1_hash_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Scoreboard: SHA-1 model plus the queue of digest words still to come
    class sha1_digest_board;
        typedef struct packed {
            logic [31:0] word;
            logic [2:0]  idx;
            logic        last;
        } digest_entry_t;

        logic [31:0]   chain [0:4];
        logic [7:0]    blk [0:63];
        logic [63:0]   nbits;
        digest_entry_t digest_queue [$];
        int            errors;
        int            messages;
        int            bytes_taken;
        int            words_checked;

        function new();
            errors = 0;
            messages = 0;
            bytes_taken = 0;
            words_checked = 0;
            for (int i = 0; i < 64; i++)
                blk[i] = 8'h00;
            restart_chain();
        endfunction

        function void restart_chain();
            chain[0] = 32'h67452301;
            chain[1] = 32'hEFCDAB89;
            chain[2] = 32'h98BADCFE;
            chain[3] = 32'h10325476;
            chain[4] = 32'hC3D2E1F0;
            nbits = 64'd0;
        endfunction

        // 80 rounds over the current block, folded into the chaining words
        function void run_rounds();
            logic [31:0] w [0:79];
            logic [31:0] a, b, c, d, e, f, k, t, x;
            for (int r = 0; r < 16; r++)
                w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
            for (int r = 16; r < 80; r++)
            begin
                x = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
                w[r] = {x[30:0], x[31]};
            end
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            e = chain[4];
            for (int r = 0; r < 80; r++)
            begin
                if (r < 20)
                begin
                    f = (b & c) | (~b & d);
                    k = 32'h5A827999;
                end
                else if (r < 40)
                begin
                    f = b ^ c ^ d;
                    k = 32'h6ED9EBA1;
                end
                else if (r < 60)
                begin
                    f = (b & c) | (b & d) | (c & d);
                    k = 32'h8F1BBCDC;
                end
                else
                begin
                    f = b ^ c ^ d;
                    k = 32'hCA62C1D6;
                end
                t = {a[26:0], a[31:27]} + f + e + k + w[r];
                e = d;
                d = c;
                c = {b[1:0], b[31:2]};
                b = a;
                a = t;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
            chain[4] += e;
        endfunction

        // Accepted input word: absorb the byte, pad and queue the digest on end
        function void note_word(logic [7:0] b, logic bv, logic eom);
            int unsigned p;
            logic [63:0] len;
            if (bv)
            begin
                p = nbits[8:3];
                blk[p] = b;
                nbits += 64'd8;
                bytes_taken++;
                if (p == 63)
                    run_rounds();
            end
            if (!eom)
                return;
            len = nbits;
            p = nbits[8:3];
            blk[p] = 8'h80;
            p++;
            // marker past byte 55: length goes into an extra block
            if (p > 56)
            begin
                while (p < 64)
                begin
                    blk[p] = 8'h00;
                    p++;
                end
                run_rounds();
                p = 0;
            end
            while (p < 56)
            begin
                blk[p] = 8'h00;
                p++;
            end
            for (int i = 0; i < 8; i++)
                blk[56+i] = len[63-8*i -: 8];
            run_rounds();
            for (int i = 0; i < 5; i++)
                digest_queue.push_back('{chain[i], 3'(i), i == 4});
            restart_chain();
            messages++;
        endfunction

        // Accepted output word: compare with the oldest expected digest word
        function void check_word(logic [31:0] word, logic [2:0] idx, logic last);
            digest_entry_t exp_w;
            if (digest_queue.size() == 0)
            begin
                $error("unexpected digest word %h (index %0d)", word, idx);
                errors++;
                return;
            end
            exp_w = digest_queue.pop_front();
            words_checked++;
            if (word !== exp_w.word)
            begin
                $error("digest_word: expected %h, actual %h", exp_w.word, word);
                errors++;
            end
            if (idx !== exp_w.idx)
            begin
                $error("word_index: expected %0d, actual %0d", exp_w.idx, idx);
                errors++;
            end
            if (last !== exp_w.last)
            begin
                $error("last_word: expected %0b, actual %0b", exp_w.last, last);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    sha1_in_if  msg_ch ();
    sha1_out_if dig_ch ();

    sha1_hash_engine uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_ch),
        .digest (dig_ch)
    );

    sha1_digest_board board;
    int unsigned      send_idle_pct;
    int unsigned      recv_idle_pct;
    bit               hold_req;
    int               items_sent;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: random ready, long hold-off on request, check each word taken
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        dig_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && dig_ch.valid && dig_ch.ready)
                board.check_word(dig_ch.digest_word, dig_ch.word_index, dig_ch.last_word);
            if (hold_req)
            begin
                hold_left = 400;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                dig_ch.ready <= 1'b0;
            end
            else
                dig_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one word with a random gap in front, wait until it is taken
    task automatic send_word(input logic [7:0] b, input logic bv, input logic eom);
        if ($urandom_range(99) < send_idle_pct)
        begin
            msg_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        msg_ch.valid          <= 1'b1;
        msg_ch.msg_byte       <= b;
        msg_ch.byte_valid     <= bv;
        msg_ch.end_of_message <= eom;
        do
            @(posedge clk);
        while (!msg_ch.ready);
        board.note_word(b, bv, eom);
        if (bv || eom)
            items_sent++;
    endtask

    // One message: bytes of a chosen style, end on the last byte or an empty end word
    task automatic send_message(input int len, input bit end_on_byte, input int style);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            // occasional ignored word in the middle of a message
            if ($urandom_range(99) < 8)
                send_word(8'($urandom), 1'b0, 1'b0);
            case (style)
                0: b = 8'h00;
                1: b = 8'hFF;
                default: b = 8'($urandom);
            endcase
            send_word(b, 1'b1, end_on_byte && (i == len - 1));
        end
        if (!end_on_byte || len == 0)
            send_word(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic send_random_message();
        int len;
        int pick;
        pick = $urandom_range(9);
        if (pick < 5)
            len = $urandom_range(12);
        else if (pick < 8)
        begin
            // lengths around the padding boundaries
            case ($urandom_range(5))
                0: len = 55;
                1: len = 56;
                2: len = 57;
                3: len = 63;
                4: len = 64;
                default: len = 65;
            endcase
        end
        else if (pick == 8)
            len = $urandom_range(140);
        else
        begin
            case ($urandom_range(2))
                0: len = 119;
                1: len = 120;
                default: len = 128;
            endcase
        end
        send_message(len, $urandom_range(1), ($urandom_range(9) == 0) ? $urandom_range(1) : 2);
    endtask

    // Main sequence
    initial
    begin : stimulus
        int phase_start;
        board = new();
        items_sent = 0;
        hold_req = 1'b0;
        send_idle_pct = 21;
        recv_idle_pct = 85;
        rst_n <= 1'b0;
        msg_ch.valid <= 1'b0;
        msg_ch.msg_byte <= 8'h00;
        msg_ch.byte_valid <= 1'b0;
        msg_ch.end_of_message <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message, "abc", idle words, byte extremes, both end styles
        send_word(8'hA5, 1'b0, 1'b1);
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
        send_word(8'h5A, 1'b0, 1'b0);
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'h3C, 1'b0, 1'b1);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'h80, 1'b1, 1'b1);
        send_word(8'h7F, 1'b1, 1'b0);
        send_word(8'h01, 1'b1, 1'b1);
        send_word(8'h00, 1'b0, 1'b1);
        send_word(8'hFF, 1'b0, 1'b1);
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'hFF, 1'b1, 1'b1);

        // Random: three idling profiles, long receiver hold-off in the last one
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 21;
                    recv_idle_pct = 85;
                end
                1:
                begin
                    send_idle_pct = 85;
                    recv_idle_pct = 21;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_req = 1'b1;
                end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < 45 || (ph == 2 && board.messages < 14))
                send_random_message();
        end

        // Drain
        msg_ch.valid <= 1'b0;
        while (board.digest_queue.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        $display("Covered %0d messages, %0d message bytes, %0d digest words checked.",
                 board.messages, board.bytes_taken, board.words_checked);
        $display("Included empty messages, padding-boundary lengths and a long output stall.");
        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
